FILE: src/p1tes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p1tes_pkg
// Shared types and constants of the P1 triangle element stiffness block.
// ----------------------------------------------------------------------------
package p1tes_pkg;

    localparam int NODE_BITS = 16;
    localparam int MATERIALS = 4;
    localparam int COND_BITS = 32;
    localparam int CFG_IDX_BITS = 8;
    localparam int DIFF_BITS = 33;
    localparam int PROD_BITS = 66;
    localparam int DELTA_BITS = 66;
    localparam int VAL_BITS = 48;
    localparam int REM_BITS = 116;
    localparam int QUO_BITS = 48;
    localparam int MAT_SEL_BITS = $clog2(MATERIALS) > 0 ? $clog2(MATERIALS) : 1;

    localparam logic [VAL_BITS-1:0] VAL_POS_MAX = {1'b0, {(VAL_BITS-1){1'b1}}};
    localparam logic [VAL_BITS-1:0] VAL_NEG_MAX = {1'b1, {(VAL_BITS-1){1'b0}}};
    localparam logic [COND_BITS-1:0] COND_RESET = 32'h0001_0000;

    typedef struct packed {
        logic [2:0][NODE_BITS-1:0] node;
        logic [2:0][DIFF_BITS-1:0] bx;
        logic [2:0][DIFF_BITS-1:0] by;
        logic [DELTA_BITS-1:0]     delta;
        logic [COND_BITS-1:0]      k;
    } tri_t;

    typedef struct packed {
        logic valid;
        logic ready;
    } hs_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_MUL_X,
        B_MUL_Y,
        B_DOT,
        B_KLO,
        B_KHI,
        B_NUM,
        B_OVF,
        B_DIV,
        B_OUT
    } back_state_t;

endpackage

FILE: src/p1tes_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p1tes_front
// Request intake: conductivity registers, gradient differences and Delta.
// ----------------------------------------------------------------------------
module p1tes_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [p1tes_pkg::NODE_BITS-1:0]      node_a,
    input  logic [p1tes_pkg::NODE_BITS-1:0]      node_b,
    input  logic [p1tes_pkg::NODE_BITS-1:0]      node_c,
    input  logic signed [31:0]                   xa,
    input  logic signed [31:0]                   ya,
    input  logic signed [31:0]                   xb,
    input  logic signed [31:0]                   yb,
    input  logic signed [31:0]                   xc,
    input  logic signed [31:0]                   yc,
    input  logic [1:0]                           material,
    input  logic                                 cfg_we,
    input  logic [p1tes_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [p1tes_pkg::COND_BITS-1:0]      cfg_data,
    output p1tes_pkg::hs_t                       out_hs,
    input  logic                                 out_ready,
    output p1tes_pkg::tri_t                      out_data
);

    logic [p1tes_pkg::COND_BITS-1:0] cond_reg [p1tes_pkg::MATERIALS];

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;
    p1tes_pkg::tri_t s1_reg, s2_reg, s3_reg;
    logic signed [p1tes_pkg::PROD_BITS-1:0] p1_reg, p2_reg;
    logic signed [p1tes_pkg::PROD_BITS:0]   dsum;
    logic [p1tes_pkg::PROD_BITS:0]          dabs;
    logic [p1tes_pkg::MAT_SEL_BITS-1:0]     sel;
    p1tes_pkg::tri_t s1_next, s3_next;

    assign rdy3 = !v3_reg || out_ready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign full = !rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int m = 0; m < p1tes_pkg::MATERIALS; m++)
            begin
                cond_reg[m] <= p1tes_pkg::COND_RESET;
            end
        end
        else if (cfg_we && cfg_index < p1tes_pkg::CFG_IDX_BITS'(p1tes_pkg::MATERIALS))
        begin
            cond_reg[cfg_index[p1tes_pkg::MAT_SEL_BITS-1:0]] <= cfg_data;
        end
    end

    always_comb
    begin
        if (32'(material) >= p1tes_pkg::MATERIALS)
        begin
            sel = '0;
        end
        else
        begin
            sel = p1tes_pkg::MAT_SEL_BITS'(material);
        end
        s1_next       = '0;
        s1_next.node[0] = node_a;
        s1_next.node[1] = node_b;
        s1_next.node[2] = node_c;
        s1_next.bx[0] = 33'($signed(xc)) - 33'($signed(xb));
        s1_next.bx[1] = 33'($signed(xa)) - 33'($signed(xc));
        s1_next.bx[2] = 33'($signed(xb)) - 33'($signed(xa));
        s1_next.by[0] = 33'($signed(yb)) - 33'($signed(yc));
        s1_next.by[1] = 33'($signed(yc)) - 33'($signed(ya));
        s1_next.by[2] = 33'($signed(ya)) - 33'($signed(yb));
        s1_next.k     = cond_reg[sel];
    end

    assign dsum = 67'(p1_reg) - 67'(p2_reg);
    assign dabs = dsum[p1tes_pkg::PROD_BITS] ? 67'(-dsum) : 67'(dsum);

    always_comb
    begin
        s3_next       = s2_reg;
        s3_next.delta = dabs[p1tes_pkg::DELTA_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= push;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && push)
        begin
            s1_reg <= s1_next;
        end
        if (rdy2 && v1_reg)
        begin
            s2_reg <= s1_reg;
            p1_reg <= $signed(s1_reg.bx[2]) * $signed(s1_reg.by[1]);
            p2_reg <= $signed(s1_reg.bx[1]) * $signed(s1_reg.by[2]);
        end
        if (rdy3 && v2_reg)
        begin
            s3_reg <= s3_next;
        end
    end

    assign out_hs.valid = v3_reg;
    assign out_hs.ready = rdy1;
    assign out_data     = s3_reg;

endmodule

FILE: src/p1tes_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p1tes_queue
// Two-entry queue of prepared triangles between intake and compute.
// ----------------------------------------------------------------------------
module p1tes_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  p1tes_pkg::hs_t  in_hs,
    output logic            in_ready,
    input  p1tes_pkg::tri_t in_data,
    output logic            out_valid,
    input  logic            out_pop,
    output p1tes_pkg::tri_t out_data
);

    p1tes_pkg::tri_t mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_wr, do_rd;

    assign in_ready  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign do_wr     = in_hs.valid && in_ready;
    assign do_rd     = out_pop && out_valid;
    assign out_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

endmodule

FILE: src/p1tes_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p1tes_back
// Entry sequencer: dot products, conductivity scaling, radix-2 division,
// rounding, saturation and the result register.
// ----------------------------------------------------------------------------
module p1tes_back (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    input  p1tes_pkg::tri_t                            in_data,
    output logic                                       in_pop,
    output logic                                       empty,
    input  logic                                       pop,
    output logic [p1tes_pkg::NODE_BITS-1:0]            row_node,
    output logic [p1tes_pkg::NODE_BITS-1:0]            col_node,
    output logic signed [p1tes_pkg::VAL_BITS-1:0]      entry_value,
    output logic                                       degenerate,
    output logic                                       last
);

    p1tes_pkg::back_state_t state_reg, state_next;
    logic [1:0] i_reg, i_next, j_reg, j_next;
    logic [5:0] cnt_reg, cnt_next;

    logic signed [p1tes_pkg::PROD_BITS-1:0] prod_reg, acc_reg;
    logic [p1tes_pkg::DELTA_BITS-1:0]       mag_reg;
    logic                                   neg_reg;
    logic [64:0]                            part_reg, hi_reg;
    logic [p1tes_pkg::REM_BITS-1:0]         rem_reg, d_reg;
    logic [p1tes_pkg::QUO_BITS-1:0]         q_reg;
    logic                                   ovf_reg;

    logic out_valid_reg;
    logic out_free, out_load;
    logic degen;
    logic signed [p1tes_pkg::PROD_BITS:0] dot_sum;
    logic [p1tes_pkg::PROD_BITS:0]        dot_abs;
    logic [97:0]                          kprod;
    logic [p1tes_pkg::REM_BITS-1:0]       num;
    logic                                 ge;
    logic [p1tes_pkg::VAL_BITS-1:0]       mag_out, val_out;
    logic                                 last_entry;

    assign degen      = in_data.delta == '0;
    assign out_free   = !out_valid_reg || pop;
    assign last_entry = i_reg == 2'd2 && j_reg == 2'd2;
    assign dot_sum    = 67'(acc_reg) + 67'(prod_reg);
    assign dot_abs    = dot_sum[p1tes_pkg::PROD_BITS] ? 67'(-dot_sum) : 67'(dot_sum);
    assign kprod      = {hi_reg, 33'b0} + {33'b0, part_reg};
    assign num        = {10'b0, kprod, 8'b0} + {50'b0, in_data.delta};
    assign ge         = rem_reg >= d_reg;

    always_comb
    begin
        if (ovf_reg)
        begin
            mag_out = neg_reg ? p1tes_pkg::VAL_NEG_MAX : p1tes_pkg::VAL_POS_MAX;
        end
        else if (!neg_reg && q_reg > p1tes_pkg::VAL_POS_MAX)
        begin
            mag_out = p1tes_pkg::VAL_POS_MAX;
        end
        else if (neg_reg && q_reg > p1tes_pkg::VAL_NEG_MAX)
        begin
            mag_out = p1tes_pkg::VAL_NEG_MAX;
        end
        else
        begin
            mag_out = q_reg;
        end
        if (degen)
        begin
            val_out = '0;
        end
        else if (neg_reg)
        begin
            val_out = -mag_out;
        end
        else
        begin
            val_out = mag_out;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        cnt_next   = cnt_reg;
        in_pop     = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            p1tes_pkg::B_IDLE:
            begin
                i_next = 2'd0;
                j_next = 2'd0;
                if (in_valid)
                begin
                    state_next = degen ? p1tes_pkg::B_OUT : p1tes_pkg::B_MUL_X;
                end
            end
            p1tes_pkg::B_MUL_X: state_next = p1tes_pkg::B_MUL_Y;
            p1tes_pkg::B_MUL_Y: state_next = p1tes_pkg::B_DOT;
            p1tes_pkg::B_DOT:   state_next = p1tes_pkg::B_KLO;
            p1tes_pkg::B_KLO:   state_next = p1tes_pkg::B_KHI;
            p1tes_pkg::B_KHI:   state_next = p1tes_pkg::B_NUM;
            p1tes_pkg::B_NUM:   state_next = p1tes_pkg::B_OVF;
            p1tes_pkg::B_OVF:
            begin
                cnt_next   = 6'(p1tes_pkg::QUO_BITS - 1);
                state_next = p1tes_pkg::B_DIV;
            end
            p1tes_pkg::B_DIV:
            begin
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    state_next = p1tes_pkg::B_OUT;
                end
            end
            p1tes_pkg::B_OUT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (last_entry)
                    begin
                        in_pop     = 1'b1;
                        state_next = p1tes_pkg::B_IDLE;
                    end
                    else
                    begin
                        if (j_reg == 2'd2)
                        begin
                            j_next = 2'd0;
                            i_next = i_reg + 2'd1;
                        end
                        else
                        begin
                            j_next = j_reg + 2'd1;
                        end
                        state_next = degen ? p1tes_pkg::B_OUT : p1tes_pkg::B_MUL_X;
                    end
                end
            end
            default: state_next = p1tes_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= p1tes_pkg::B_IDLE;
            i_reg         <= 2'd0;
            j_reg         <= 2'd0;
            cnt_reg       <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            cnt_reg   <= cnt_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            p1tes_pkg::B_IDLE:
            begin
                neg_reg <= 1'b0;
                ovf_reg <= 1'b0;
                q_reg   <= '0;
            end
            p1tes_pkg::B_MUL_X:
            begin
                prod_reg <= $signed(in_data.bx[i_reg]) * $signed(in_data.bx[j_reg]);
            end
            p1tes_pkg::B_MUL_Y:
            begin
                acc_reg  <= prod_reg;
                prod_reg <= $signed(in_data.by[i_reg]) * $signed(in_data.by[j_reg]);
            end
            p1tes_pkg::B_DOT:
            begin
                neg_reg <= dot_sum[p1tes_pkg::PROD_BITS];
                mag_reg <= dot_abs[p1tes_pkg::DELTA_BITS-1:0];
            end
            p1tes_pkg::B_KLO:
            begin
                part_reg <= mag_reg[32:0] * in_data.k;
            end
            p1tes_pkg::B_KHI:
            begin
                hi_reg <= mag_reg[65:33] * in_data.k;
            end
            p1tes_pkg::B_NUM:
            begin
                rem_reg <= num;
                d_reg   <= {2'b0, in_data.delta, 48'b0};
            end
            p1tes_pkg::B_OVF:
            begin
                ovf_reg <= rem_reg >= {1'b0, in_data.delta, 49'b0};
            end
            p1tes_pkg::B_DIV:
            begin
                if (ge)
                begin
                    rem_reg <= rem_reg - d_reg;
                end
                d_reg <= {1'b0, d_reg[p1tes_pkg::REM_BITS-1:1]};
                q_reg <= {q_reg[p1tes_pkg::QUO_BITS-2:0], ge};
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            row_node    <= in_data.node[i_reg];
            col_node    <= in_data.node[j_reg];
            entry_value <= val_out;
            degenerate  <= degen;
            last        <= last_entry;
        end
    end

    assign empty = !out_valid_reg;

endmodule

FILE: src/p1_triangle_element_stiffness.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p1_triangle_element_stiffness
// Local 3x3 conduction stiffness of a linear triangle, nine triplets per
// request, Q24.24 saturated values.
// ----------------------------------------------------------------------------
// Path: an accepted request passes two more intake stages and the queue write,
// then the sequencer steps through MUL_X, MUL_Y, DOT, KLO, KHI, NUM, OVF, the
// radix-2 divider of 48 quotient bits and OUT for each result, one result at a
// time; when Delta is zero it goes straight to OUT, one result per cycle while
// the output register is free. Intake runs ahead through a two-entry queue.
// Reset: asynchronous, active low; conductivities return to 1.0, no
// clearing pass.
// ----------------------------------------------------------------------------
module p1_triangle_element_stiffness (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic [p1tes_pkg::NODE_BITS-1:0]        node_a,
    input  logic [p1tes_pkg::NODE_BITS-1:0]        node_b,
    input  logic [p1tes_pkg::NODE_BITS-1:0]        node_c,
    input  logic signed [31:0]                     xa,
    input  logic signed [31:0]                     ya,
    input  logic signed [31:0]                     xb,
    input  logic signed [31:0]                     yb,
    input  logic signed [31:0]                     xc,
    input  logic signed [31:0]                     yc,
    input  logic [1:0]                             material,
    input  logic                                   cfg_we,
    input  logic [p1tes_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [p1tes_pkg::COND_BITS-1:0]        cfg_data,
    output logic                                   empty,
    input  logic                                   pop,
    output logic [p1tes_pkg::NODE_BITS-1:0]        row_node,
    output logic [p1tes_pkg::NODE_BITS-1:0]        col_node,
    output logic signed [p1tes_pkg::VAL_BITS-1:0]  entry_value,
    output logic                                   degenerate,
    output logic                                   last
);

    p1tes_pkg::hs_t  front_hs;
    p1tes_pkg::tri_t front_data, head_data;
    logic q_ready, q_valid, q_pop;

    p1tes_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .node_a    (node_a),
        .node_b    (node_b),
        .node_c    (node_c),
        .xa        (xa),
        .ya        (ya),
        .xb        (xb),
        .yb        (yb),
        .xc        (xc),
        .yc        (yc),
        .material  (material),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_hs    (front_hs),
        .out_ready (q_ready),
        .out_data  (front_data)
    );

    p1tes_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_hs     (front_hs),
        .in_ready  (q_ready),
        .in_data   (front_data),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_data  (head_data)
    );

    p1tes_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (q_valid),
        .in_data     (head_data),
        .in_pop      (q_pop),
        .empty       (empty),
        .pop         (pop),
        .row_node    (row_node),
        .col_node    (col_node),
        .entry_value (entry_value),
        .degenerate  (degenerate),
        .last        (last)
    );

endmodule

FILE: test/tb_p1_triangle_element_stiffness.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_p1_triangle_element_stiffness
// Self-checking regression for the P1 triangle stiffness block. Triangles are
// pushed in random bursts while results are popped on a random stall pattern.
// A wide-integer predictor computes the nine expected triplets of each
// accepted request. The conductivity registers are rewritten between phases,
// including zero, full scale and an out-of-range index.
// ----------------------------------------------------------------------------
module tb_p1_triangle_element_stiffness;

    localparam logic [p1tes_pkg::CFG_IDX_BITS-1:0] REG_COND0 = 8'd0;
    localparam logic [p1tes_pkg::CFG_IDX_BITS-1:0] REG_COND1 = 8'd1;
    localparam logic [p1tes_pkg::CFG_IDX_BITS-1:0] REG_COND2 = 8'd2;
    localparam logic [p1tes_pkg::CFG_IDX_BITS-1:0] REG_COND3 = 8'd3;
    localparam logic [p1tes_pkg::CFG_IDX_BITS-1:0] REG_NONE  = 8'd9;

    typedef struct {
        logic [p1tes_pkg::NODE_BITS-1:0] na, nb, nc;
        logic signed [31:0]              ax, ay, bx, by, cx, cy;
        logic [1:0]                      mat;
    } triangle_t;

    typedef struct {
        logic [p1tes_pkg::NODE_BITS-1:0] row, col;
        logic [p1tes_pkg::VAL_BITS-1:0]  val;
        logic                            degen, lst;
    } triplet_t;

    logic clk = 1'b0;
    logic rst_n;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full, empty;
    logic [p1tes_pkg::NODE_BITS-1:0] node_a = '0;
    logic [p1tes_pkg::NODE_BITS-1:0] node_b = '0;
    logic [p1tes_pkg::NODE_BITS-1:0] node_c = '0;
    logic [p1tes_pkg::NODE_BITS-1:0] row_node, col_node;
    logic signed [31:0] xa = '0;
    logic signed [31:0] ya = '0;
    logic signed [31:0] xb = '0;
    logic signed [31:0] yb = '0;
    logic signed [31:0] xc = '0;
    logic signed [31:0] yc = '0;
    logic [1:0] material = '0;
    logic cfg_we;
    logic [p1tes_pkg::CFG_IDX_BITS-1:0] cfg_index;
    logic [p1tes_pkg::COND_BITS-1:0] cfg_data;
    logic signed [p1tes_pkg::VAL_BITS-1:0] entry_value;
    logic degenerate, last;

    triangle_t pending[$];
    triplet_t  expected_triplets[$];
    logic [p1tes_pkg::COND_BITS-1:0] cond_copy[4];
    int errors = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_age = 0;
    logic [7:0] stall_pat = 8'hFF;
    logic [2:0] stall_ptr = 3'd0;

    p1_triangle_element_stiffness u_top (.*);

    always #6 clk = ~clk;

    function automatic void predict_stiffness(triangle_t t);
        logic signed [127:0] gx[3], gy[3];
        logic signed [127:0] area, dot;
        logic [127:0] delta, mag, num, quo;
        logic [p1tes_pkg::NODE_BITS-1:0] nodes[3];
        logic [p1tes_pkg::COND_BITS-1:0] k;
        logic neg;
        triplet_t r;
        nodes[0] = t.na;
        nodes[1] = t.nb;
        nodes[2] = t.nc;
        k = cond_copy[t.mat];
        gx[0] = 128'(longint'(t.cx) - longint'(t.bx));
        gx[1] = 128'(longint'(t.ax) - longint'(t.cx));
        gx[2] = 128'(longint'(t.bx) - longint'(t.ax));
        gy[0] = 128'(longint'(t.by) - longint'(t.cy));
        gy[1] = 128'(longint'(t.cy) - longint'(t.ay));
        gy[2] = 128'(longint'(t.ay) - longint'(t.by));
        area = gx[2] * gy[1] - gx[1] * gy[2];
        delta = area < 0 ? -area : area;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                r.row = nodes[i];
                r.col = nodes[j];
                r.degen = (delta == 0);
                r.lst = (i == 2 && j == 2);
                r.val = '0;
                if (delta != 0)
                begin
                    dot = gx[i] * gx[j] + gy[i] * gy[j];
                    neg = dot < 0;
                    mag = neg ? -dot : dot;
                    num = ((mag * {96'b0, k}) << 8) + delta;
                    quo = num / (delta << 1);
                    if (neg)
                    begin
                        if (quo > 128'(p1tes_pkg::VAL_NEG_MAX))
                            quo = 128'(p1tes_pkg::VAL_NEG_MAX);
                        r.val = -quo[p1tes_pkg::VAL_BITS-1:0];
                    end
                    else
                    begin
                        if (quo > 128'(p1tes_pkg::VAL_POS_MAX))
                            quo = 128'(p1tes_pkg::VAL_POS_MAX);
                        r.val = quo[p1tes_pkg::VAL_BITS-1:0];
                    end
                end
                expected_triplets.insert(expected_triplets.size(), r);
            end
        end
    endfunction

    // driver: bursts of requests separated by random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                predict_stiffness(pending[0]);
                void'(pending.pop_front());
            end
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                push <= 1'b0;
            end
            else if (pending.size() > 0 && !(push && !full && pending.size() == 0))
            begin
                push <= 1'b1;
                node_a <= pending[0].na;
                node_b <= pending[0].nb;
                node_c <= pending[0].nc;
                xa <= pending[0].ax;
                ya <= pending[0].ay;
                xb <= pending[0].bx;
                yb <= pending[0].by;
                xc <= pending[0].cx;
                yc <= pending[0].cy;
                material <= pending[0].mat;
                if (push && !full)
                begin
                    if (burst_left > 0)
                        burst_left <= burst_left - 1;
                    else
                    begin
                        burst_left <= $urandom_range(0, 6);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    end
                end
            end
            else
                push <= 1'b0;
        end
    end

    // monitor: pop on a rotating stall pattern, compare against predictions
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_triplets.size() == 0)
                begin
                    $error("unexpected triplet row=%0d col=%0d", row_node, col_node);
                    errors++;
                end
                else
                begin
                    if (row_node !== expected_triplets[0].row)
                    begin
                        $error("row_node exp %0d got %0d", expected_triplets[0].row, row_node);
                        errors++;
                    end
                    if (col_node !== expected_triplets[0].col)
                    begin
                        $error("col_node exp %0d got %0d", expected_triplets[0].col, col_node);
                        errors++;
                    end
                    if (entry_value !== expected_triplets[0].val)
                    begin
                        $error("entry_value exp %h got %h", expected_triplets[0].val,
                               entry_value);
                        errors++;
                    end
                    if (degenerate !== expected_triplets[0].degen)
                    begin
                        $error("degenerate exp %b got %b", expected_triplets[0].degen,
                               degenerate);
                        errors++;
                    end
                    if (last !== expected_triplets[0].lst)
                    begin
                        $error("last exp %b got %b", expected_triplets[0].lst, last);
                        errors++;
                    end
                    void'(expected_triplets.pop_front());
                end
            end
            if (stall_age == 63)
            begin
                stall_age <= 0;
                stall_pat <= ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom());
            end
            else
                stall_age <= stall_age + 1;
            stall_ptr <= stall_ptr + 3'd1;
            pop <= stall_pat[stall_ptr];
        end
    end

    task automatic write_cond(input logic [p1tes_pkg::CFG_IDX_BITS-1:0] idx,
                              input logic [p1tes_pkg::COND_BITS-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx < 4)
            cond_copy[idx[1:0]] = data;
    endtask

    task automatic drain;
        while (pending.size() > 0 || expected_triplets.size() > 0 || push)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic add_triangle(input logic signed [31:0] ax, ay, bx, by, cx, cy,
                                input logic [1:0] mat);
        triangle_t t;
        t.na = 16'($urandom());
        t.nb = 16'($urandom());
        t.nc = 16'($urandom());
        t.ax = ax;
        t.ay = ay;
        t.bx = bx;
        t.by = by;
        t.cx = cx;
        t.cy = cy;
        t.mat = mat;
        pending.insert(pending.size(), t);
    endtask

    task automatic add_random(input int count);
        logic signed [31:0] p[6];
        int span;
        int sel;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(0, 9);
            span = $urandom_range(4, 30);
            for (int i = 0; i < 6; i++)
            begin
                if (sel < 2)
                    p[i] = $urandom();
                else
                    p[i] = $signed($urandom_range(0, (1 << span) - 1)) - (1 << (span - 1));
            end
            if (sel == 2)
            begin
                p[4] = p[0];
                p[5] = p[1];
            end
            else if (sel == 3)
            begin
                p[4] = p[2] + (p[2] - p[0]);
                p[5] = p[3] + (p[3] - p[1]);
            end
            add_triangle(p[0], p[1], p[2], p[3], p[4], p[5], 2'($urandom()));
        end
    endtask

    initial
    begin
        triangle_t t;
        rst_n = 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        for (int i = 0; i < 4; i++)
            cond_copy[i] = p1tes_pkg::COND_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unit right triangle, all materials, extreme nodes
        t = '{16'h0000, 16'hFFFF, 16'h1234, 0, 0, 32'h10000, 0, 0, 32'h10000, 2'd0};
        pending.insert(pending.size(), t);
        for (int m = 1; m < 4; m++)
            add_triangle(0, 0, 32'h10000, 0, 0, 32'h10000, 2'(m));
        t = '{16'hFFFF, 16'h0000, 16'hFFFF, 0, 0, 32'h30000, 32'h10000, 32'h8000,
              32'h20000, 2'd2};
        pending.insert(pending.size(), t);
        // extreme coordinates
        add_triangle(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
                     32'sh80000000, 32'sh80000000, 2'd3);
        add_triangle(32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
                     32'sh7FFFFFFF, 32'sh7FFFFFFF, 2'd1);
        add_triangle(32'sh80000000, 0, 32'sh7FFFFFFF, 0, 0, 32'sh7FFFFFFF, 2'd0);
        // sliver triangles: tiny area, large gradients
        add_triangle(0, 0, 32'sh7FFFFFFF, 0, 32'sh7FFFFFFF, 1, 2'd0);
        add_triangle(0, 0, 32'sh40000000, 1, 32'sh80000000, 0, 2'd2);
        add_triangle(0, 0, 1, 0, 0, 1, 2'd1);
        // zero area: identical points, collinear, coincident pair
        add_triangle(5, 5, 5, 5, 5, 5, 2'd0);
        add_triangle(0, 0, 32'h10000, 32'h10000, 32'h20000, 32'h20000, 2'd3);
        add_triangle(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                     32'sh7FFFFFFF, 32'sh7FFFFFFF, 2'd1);
        add_triangle(-32'sh10000, 32'h10000, 32'h10000, -32'sh10000, 0, 0, 2'd2);
        add_triangle(0, 0, 0, 0, 0, 0, 2'd3);
        // winding reversed
        add_triangle(0, 0, 0, 32'h10000, 32'h10000, 0, 2'd0);
        add_random(20);
        drain();

        // extremes of conductivity, unused register index
        write_cond(REG_COND0, 32'h0000_0000);
        write_cond(REG_COND1, 32'hFFFF_FFFF);
        write_cond(REG_COND2, 32'h0000_0001);
        write_cond(REG_COND3, 32'h8000_0000);
        write_cond(REG_NONE, 32'h1234_5678);
        add_triangle(0, 0, 1, 0, 0, 1, 2'd1);
        add_triangle(32'sh80000000, 0, 32'sh7FFFFFFF, 0, 0, 32'sh7FFFFFFF, 2'd1);
        add_triangle(0, 0, 32'sh7FFFFFFF, 0, 32'sh7FFFFFFF, 1, 2'd3);
        add_random(110);
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            write_cond(REG_COND0, $urandom());
            write_cond(REG_COND1, $urandom_range(0, 32'h0004_0000));
            write_cond(REG_COND2, $urandom());
            write_cond(REG_COND3, (ph == 2) ? 32'hFFFF_FFFF : $urandom_range(0, 32'h100));
            add_random(115);
            drain();
        end

        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("p1_triangle_element_stiffness regression: pass");
        else
            $display("p1_triangle_element_stiffness regression: fail");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("p1_triangle_element_stiffness regression: fail");
        $finish;
    end

endmodule

FILE: files.f
src/p1tes_pkg.sv
src/p1tes_front.sv
src/p1tes_queue.sv
src/p1tes_back.sv
src/p1_triangle_element_stiffness.sv
test/tb_p1_triangle_element_stiffness.sv
